[rtl/bsd_pkg.sv]
// shared types, constants and helpers for the bounded stack with delete
package bsd_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_BITS  = 32;
   localparam int COUNT_BITS  = $clog2(DEPTH + 1);
   localparam int IDX_BITS    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIMIT_BITS  = 5;
   localparam int OPCODE_BITS = 3;
   localparam int TOP_BITS    = 32;
   localparam int COUNT_OUT_BITS = 5;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   localparam logic [OPCODE_BITS-1:0] OP_PUSH   = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_POP    = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_PEEK   = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_DELETE = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_GROW   = 3'd4;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic signed [31:0]     operand;
   } req_type;

   typedef struct packed {
      logic signed [TOP_BITS-1:0]   top_value;
      status_type                   status;
      logic                         is_empty;
      logic [COUNT_OUT_BITS-1:0]    entry_count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // clamp a candidate limit into 1..DEPTH
   function automatic logic [COUNT_BITS-1:0] clamp_limit(input logic [COUNT_BITS:0] value);
      logic [COUNT_BITS-1:0] result;
      if (value == '0) begin
         result = COUNT_BITS'(1);
      end else if (value > (COUNT_BITS + 1)'(DEPTH)) begin
         result = COUNT_BITS'(DEPTH);
      end else begin
         result = value[COUNT_BITS-1:0];
      end
      return result;
   endfunction

endpackage

[rtl/bsd_cell.sv]
// one stack cell: holds an entry, compares it and shifts down on delete
module bsd_cell (
   input  logic                           clock,
   input  bsd_pkg::cell_ctl_type          ctl,
   input  logic                           valid,
   input  logic [bsd_pkg::VALUE_BITS-1:0] operand,
   input  logic [bsd_pkg::VALUE_BITS-1:0] upper_value,
   input  logic                           match_above,
   output logic [bsd_pkg::VALUE_BITS-1:0] value,
   output logic                           match_here_or_above
);
   import bsd_pkg::*;

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   // flags a match in this cell or in any live cell above it
   assign match_here_or_above = match_above | (valid && (value_ff == operand));

   always_comb begin
      priority if (ctl.load) begin
         value_in = operand;
      end else if (ctl.shift) begin
         value_in = upper_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[rtl/bounded_stack_with_delete.sv]
// top level: bounded stack with delete built from a row of cells
// results: an accepted item's result appears in the output register in the cycle after acceptance
// throughput: one item per cycle while the receiver does not stall; push, pop, peek, delete and grow all finish in
//   the cycle of acceptance, the cell row compares and shifts in parallel
// reset: synchronous, clears the count and output valid, limit returns to 16;
//   cell contents are undefined until pushed
module bounded_stack_with_delete (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bsd_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bsd_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_enable,
   input  logic [bsd_pkg::LIMIT_BITS-1:0]    csr_write_data
);
   import bsd_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic                  is_full;
   logic                  is_none;
   logic                  found;
   logic [VALUE_BITS-1:0] operand_bits;
   logic [VALUE_BITS-1:0] top_entry;
   logic [IDX_BITS-1:0]   top_index;

   logic [VALUE_BITS-1:0] cell_value [DEPTH];
   logic                  cell_match [DEPTH];
   cell_ctl_type          cell_ctl   [DEPTH];

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign operand_bits = VALUE_BITS'(req_data.operand);
   assign is_full      = (count_ff >= limit_ff);
   assign is_none      = (count_ff == '0);
   assign found        = cell_match[0];
   assign top_index    = IDX_BITS'(count_ff - COUNT_BITS'(1));
   assign top_entry    = cell_value[top_index];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  above_match;
      logic [VALUE_BITS-1:0] above_value;
      logic                  valid;

      if (i == DEPTH - 1) begin : g_top
         assign above_match = 1'b0;
         assign above_value = cell_value[i];
      end else begin : g_mid
         assign above_match = cell_match[i+1];
         assign above_value = cell_value[i+1];
      end

      assign valid = (COUNT_BITS'(i) < count_ff);
      assign cell_ctl[i].load = accept && (req_data.opcode == OP_PUSH) && !is_full &&
                                (count_ff == COUNT_BITS'(i));
      // cells from the topmost match upward close the gap
      assign cell_ctl[i].shift = accept && (req_data.opcode == OP_DELETE) && found &&
                                 !above_match;

      bsd_cell u_cell (
         .clock               (clock),
         .ctl                 (cell_ctl[i]),
         .valid               (valid),
         .operand             (operand_bits),
         .upper_value         (above_value),
         .match_above         (above_match),
         .value               (cell_value[i]),
         .match_here_or_above (cell_match[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      limit_in = limit_ff;
      rsp_in   = rsp_ff;
      rsp_in.top_value = '0;
      rsp_in.status    = ST_OK;
      if (accept) begin
         unique case (req_data.opcode)
            OP_PUSH: begin
               if (is_full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            OP_POP, OP_PEEK: begin
               if (is_none) begin
                  rsp_in.top_value = '1;
                  rsp_in.status    = ST_EMPTY;
               end else begin
                  rsp_in.top_value = TOP_BITS'(top_entry);
                  if (req_data.opcode == OP_POP) begin
                     count_in = count_ff - COUNT_BITS'(1);
                  end
               end
            end
            OP_DELETE: begin
               if (found) begin
                  count_in = count_ff - COUNT_BITS'(1);
               end else begin
                  rsp_in.status = ST_NOTFOUND;
               end
            end
            OP_GROW: begin
               limit_in = clamp_limit({limit_ff, 1'b0});
            end
            default: begin
               // unused opcodes leave the stack alone
            end
         endcase
         rsp_in.is_empty    = (count_in == '0);
         rsp_in.entry_count = COUNT_OUT_BITS'(count_in);
      end
      if (csr_write_enable) begin
         limit_in = clamp_limit((COUNT_BITS + 1)'(csr_write_data));
      end
   end

   always_comb begin
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= clamp_limit((COUNT_BITS + 1)'(LIMIT_RESET));
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count above depth");

   assert property (@(posedge clock) disable iff (reset)
      (limit_ff != '0) && (limit_ff <= COUNT_BITS'(DEPTH)))
      else $error("working limit out of range");

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == OP_POP) && !is_none
      |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("pop did not remove the top entry");

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == OP_PUSH) && is_full |=> $stable(count_ff))
      else $error("push on a full stack changed the count");
`endif

endmodule

[dv/tb_bounded_stack_with_delete.sv]
// self-checking testbench for the bounded stack with delete: stack predictor and result checks
`timescale 1ns / 100ps

import bsd_pkg::*;

class stack_scoreboard;
   logic signed [VALUE_BITS-1:0] cells [DEPTH];
   int depth_used;
   int limit;
   rsp_type expected_rsps [$];
   int failures;
   int reports;

   function new();
      depth_used = 0;
      limit = fit_limit(int'(LIMIT_RESET));
      failures = 0;
      reports = 0;
   endfunction

   function int fit_limit(int value);
      if (value < 1) return 1;
      if (value > DEPTH) return DEPTH;
      return value;
   endfunction

   function void load_limit(logic [LIMIT_BITS-1:0] value);
      limit = fit_limit(int'(value));
   endfunction

   function int pending();
      return expected_rsps.size();
   endfunction

   function void complain(string msg);
      failures++;
      if (reports < 10) begin
         reports++;
         $display("ERROR: %s", msg);
      end
   endfunction

   // applies one operation to the stack copy and queues the result it should give
   function void note_item(req_type item);
      rsp_type want;
      int pos;
      int j;
      bit found;
      want.top_value = '0;
      want.status = ST_OK;
      case (item.opcode)
         OP_PUSH: begin
            if (depth_used >= limit || depth_used >= DEPTH) begin
               want.status = ST_FULL;
            end else begin
               cells[depth_used] = item.operand;
               depth_used++;
            end
         end
         OP_POP, OP_PEEK: begin
            if (depth_used == 0) begin
               want.top_value = -1;
               want.status = ST_EMPTY;
            end else begin
               want.top_value = cells[depth_used-1];
               if (item.opcode == OP_POP) depth_used--;
            end
         end
         OP_DELETE: begin
            // search from the top, first match wins
            found = 1'b0;
            pos = depth_used;
            while (pos > 0 && !found) begin
               pos--;
               if (cells[pos] == item.operand) found = 1'b1;
            end
            if (found) begin
               for (j = pos; j + 1 < depth_used; j++) cells[j] = cells[j+1];
               depth_used--;
            end else begin
               want.status = ST_NOTFOUND;
            end
         end
         OP_GROW: begin
            limit = fit_limit(limit * 2);
         end
         default: begin
         end
      endcase
      want.is_empty = (depth_used == 0);
      want.entry_count = COUNT_OUT_BITS'(depth_used);
      expected_rsps.push_back(want);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         complain($sformatf("unexpected result: top %0d status %0d empty %0b count %0d",
                            got.top_value, int'(got.status), got.is_empty, got.entry_count));
         return;
      end
      want = expected_rsps.pop_front();
      if (got.top_value !== want.top_value || got.status !== want.status ||
          got.is_empty !== want.is_empty || got.entry_count !== want.entry_count) begin
         complain($sformatf({"mismatch: expected top %0d status %0d empty %0b count %0d,",
                             " got top %0d status %0d empty %0b count %0d"},
                            want.top_value, int'(want.status), want.is_empty,
                            want.entry_count, got.top_value, int'(got.status),
                            got.is_empty, got.entry_count));
      end
   endfunction

   function void close_out();
      if (expected_rsps.size() != 0)
         complain($sformatf("%0d expected results never arrived", expected_rsps.size()));
   endfunction
endclass

module tb_bounded_stack_with_delete;
   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 120;
   localparam logic [31:0] VALUE_POOL [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                                               32'h0000_0000, 32'd7, 32'd42};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [LIMIT_BITS-1:0] csr_write_data = '0;

   bit calm = 1'b0;
   bit squeeze_request = 1'b0;
   int quiet_cycles = 0;

   stack_scoreboard sb = new();

   bounded_stack_with_delete uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // results are checked before the same edge's item is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_item(req_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver side: random stalls, one long hold-off when asked
   initial begin : rsp_stall_driver
      int held;
      held = 0;
      forever begin
         @(posedge clock);
         if (squeeze_request && held < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 37);
         end
      end
   end

   task automatic send_op(input logic [OPCODE_BITS-1:0] opcode, input logic [31:0] operand);
      req_type item;
      item.opcode = opcode;
      item.operand = operand;
      if (!calm && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.load_limit(value);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type random_item(int push_weight);
      req_type item;
      int roll;
      roll = $urandom_range(99);
      if (roll < push_weight) begin
         item.opcode = OP_PUSH;
      end else begin
         roll = $urandom_range(99);
         if (roll < 30) item.opcode = OP_POP;
         else if (roll < 45) item.opcode = OP_PEEK;
         else if (roll < 80) item.opcode = OP_DELETE;
         else if (roll < 92) item.opcode = OP_GROW;
         else item.opcode = OPCODE_BITS'($urandom_range(5, 7));
      end
      // mostly pool values so deletes find matches and duplicates build up
      if ($urandom_range(3) == 0) item.operand = $urandom();
      else item.operand = VALUE_POOL[$urandom_range(5)];
      return item;
   endfunction

   task automatic run_phase(input logic [LIMIT_BITS-1:0] limit_value, input int items,
                            input int push_weight);
      req_type item;
      write_limit(limit_value);
      repeat (items) begin
         item = random_item(push_weight);
         send_op(item.opcode, item.operand);
      end
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack, extremes, unused opcodes, grow at the top limit
      send_op(OP_POP, 32'd0);
      send_op(OP_PEEK, 32'd0);
      send_op(OP_DELETE, 32'd5);
      send_op(OP_GROW, 32'd0);
      send_op(OP_PUSH, 32'h7fff_ffff);
      send_op(OP_PUSH, 32'h8000_0000);
      send_op(OP_PUSH, 32'hffff_ffff);
      send_op(OP_PUSH, 32'h0000_0000);
      send_op(OP_PEEK, 32'hffff_ffff);
      send_op(OP_DELETE, 32'hffff_ffff);
      send_op(OP_DELETE, 32'd99);
      send_op(3'd5, 32'hffff_ffff);
      send_op(3'd7, 32'h1234_5678);
      send_op(OP_POP, 32'd0);
      send_op(OP_POP, 32'd0);
      send_op(OP_POP, 32'd0);
      send_op(OP_POP, 32'd0);
      drain();

      // small limit, full push, growth, duplicate delete takes the upper one
      write_limit(5'd1);
      send_op(OP_PUSH, 32'd3);
      send_op(OP_PUSH, 32'd3);
      send_op(OP_GROW, 32'd0);
      send_op(OP_PUSH, 32'd3);
      send_op(OP_PUSH, 32'd4);
      send_op(OP_DELETE, 32'd3);
      send_op(OP_GROW, 32'd0);
      send_op(OP_PUSH, 32'd8);
      drain();

      // zero acts as one, and the limit now sits below the count
      write_limit(5'd0);
      send_op(OP_PUSH, 32'd9);
      send_op(OP_DELETE, 32'd3);
      send_op(OP_PUSH, 32'd9);
      send_op(OP_POP, 32'd0);
      send_op(OP_PUSH, 32'd9);
      drain();

      squeeze_request = 1'b1;
      run_phase(5'd31, 150, 55);
      calm = 1'b1;
      run_phase(5'd16, 150, 40);
      calm = 1'b0;
      run_phase(5'd1, 120, 50);
      run_phase(5'd17, 150, 60);
      run_phase(5'd4, 150, 30);
      repeat (5) run_phase(LIMIT_BITS'($urandom_range(0, 31)), 80, $urandom_range(25, 60));

      drain();
      repeat (4) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
